// File: src/mvm_pkg.sv
package mvm_pkg;

	localparam int MAX_VERTICES_DEF = 4096;
	localparam int COORD_BITS_DEF   = 24;

	localparam int IDX_W  = 12;
	localparam int CNT_W  = 13;
	localparam int LIM_W  = 24;
	localparam int SQ_W   = 2 * LIM_W;
	localparam int AXIS_W = 2;
	localparam int KIND_W = 2;
	localparam int REG_W  = 2;
	localparam int DATA_W = 24;

	// distance arithmetic: magnitudes at or above 2^MAG_W saturate
	localparam int MAG_W  = 26;
	localparam int DIST_W = 2 * MAG_W;
	localparam int DIFF_W = 34;
	localparam logic [DIST_W-1:0] DIST_MAX = '1;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
	localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;

	localparam logic [KIND_W-1:0] KIND_NONE  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_EXACT = 2'd1;
	localparam logic [KIND_W-1:0] KIND_NEAR  = 2'd2;

	localparam logic [REG_W-1:0] REG_AXIS  = 2'd0;
	localparam logic [REG_W-1:0] REG_NEAR  = 2'd1;
	localparam logic [REG_W-1:0] REG_EXACT = 2'd2;
	localparam logic [REG_W-1:0] REG_COUNT = 2'd3;

	localparam logic [LIM_W-1:0] NEAR_RESET = 24'd205;

	typedef struct packed {
		logic             start;
		logic [IDX_W-1:0] index;
		logic             in_range;
	} query_t;

	typedef struct packed {
		logic             load_src;
		logic             issue;
		logic             flush;
		logic [IDX_W-1:0] idx;
	} dist_ctl_t;

	typedef struct packed {
		logic              busy;
		logic              valid;
		logic [IDX_W-1:0]  idx;
		logic [DIST_W-1:0] sq_dist;
	} dist_stat_t;

	typedef struct packed {
		logic              valid;
		logic [IDX_W-1:0]  source_index;
		logic [IDX_W-1:0]  match_index;
		logic [KIND_W-1:0] match_kind;
	} rsp_t;

endpackage

// File: src/mvm_cmd_if.sv
interface mvm_cmd_if #(
	parameter int COORD_BITS = mvm_pkg::COORD_BITS_DEF
);
	logic                             valid;
	logic                             ready;
	logic                             opcode;
	logic [mvm_pkg::IDX_W-1:0]        vertex_index;
	logic signed [COORD_BITS-1:0]     coord_x;
	logic signed [COORD_BITS-1:0]     coord_y;
	logic signed [COORD_BITS-1:0]     coord_z;

	modport source (
		output valid, opcode, vertex_index, coord_x, coord_y, coord_z,
		input  ready
	);
	modport sink (
		input  valid, opcode, vertex_index, coord_x, coord_y, coord_z,
		output ready
	);
endinterface

// File: src/mvm_result_if.sv
interface mvm_result_if;
	logic                       valid;
	logic                       ready;
	logic [mvm_pkg::IDX_W-1:0]  source_index;
	logic [mvm_pkg::IDX_W-1:0]  match_index;
	logic [mvm_pkg::KIND_W-1:0] match_kind;

	modport source (
		output valid, source_index, match_index, match_kind,
		input  ready
	);
	modport sink (
		input  valid, source_index, match_index, match_kind,
		output ready
	);
endinterface

// File: src/mvm_store.sv
module mvm_store #(
	parameter int MAX_VERTICES = mvm_pkg::MAX_VERTICES_DEF,
	parameter int COORD_BITS   = mvm_pkg::COORD_BITS_DEF,
	localparam int AW          = $clog2(MAX_VERTICES),
	localparam int WW          = 3 * COORD_BITS
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [WW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [WW-1:0] rdata
);

	logic [WW-1:0] mem [MAX_VERTICES];
	logic [WW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: src/mvm_dist.sv
module mvm_dist #(
	parameter int COORD_BITS = mvm_pkg::COORD_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  mvm_pkg::dist_ctl_t          ctl,
	input  logic [mvm_pkg::AXIS_W-1:0]  axis,
	input  logic [3*COORD_BITS-1:0]     rd_word,
	output mvm_pkg::dist_stat_t         stat
);

	localparam int LANES = 3;

	logic signed [COORD_BITS:0]           src_q [LANES];
	logic signed [COORD_BITS-1:0]         rd_c [LANES];
	logic [LANES-1:0]                     neg_c;
	logic signed [mvm_pkg::DIFF_W-1:0]    diff_c [LANES];
	logic [mvm_pkg::DIFF_W-1:0]           mag_c [LANES];
	logic [mvm_pkg::DIST_W+1:0]           sum_c;

	logic                                 v_s1, v_s2, v_s3, v_s4;
	logic [mvm_pkg::IDX_W-1:0]            idx_s1, idx_s2, idx_s3, idx_s4;
	logic [mvm_pkg::MAG_W-1:0]            mag_s2 [LANES];
	logic [LANES-1:0]                     sat_s2;
	logic [mvm_pkg::DIST_W-1:0]           sq_s3 [LANES];
	logic [mvm_pkg::DIST_W-1:0]           dist_s4;

	always_comb begin
		neg_c[0] = (axis == mvm_pkg::AXIS_X);
		neg_c[1] = (axis == mvm_pkg::AXIS_Y);
		neg_c[2] = (axis != mvm_pkg::AXIS_X) && (axis != mvm_pkg::AXIS_Y);
		for (int i = 0; i < LANES; i++) begin
			rd_c[i]   = rd_word[i*COORD_BITS +: COORD_BITS];
			diff_c[i] = mvm_pkg::DIFF_W'(src_q[i]) - mvm_pkg::DIFF_W'(rd_c[i]);
			mag_c[i]  = diff_c[i][mvm_pkg::DIFF_W-1] ? mvm_pkg::DIFF_W'(-diff_c[i])
			                                          : mvm_pkg::DIFF_W'(diff_c[i]);
		end
		sum_c = (mvm_pkg::DIST_W+2)'(sq_s3[0]) + (mvm_pkg::DIST_W+2)'(sq_s3[1])
		      + (mvm_pkg::DIST_W+2)'(sq_s3[2]);
	end

	// mirrored source position, held for the whole scan
	always_ff @(posedge clk) begin
		if (ctl.load_src) begin
			for (int i = 0; i < LANES; i++) begin
				src_q[i] <= neg_c[i] ? -((COORD_BITS+1)'(rd_c[i]))
				                     : (COORD_BITS+1)'(rd_c[i]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			// drop everything in flight on an exact hit
			v_s1 <= ctl.issue && !ctl.flush;
			v_s2 <= v_s1 && !ctl.flush;
			v_s3 <= v_s2 && !ctl.flush;
			v_s4 <= v_s3 && !ctl.flush;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= ctl.idx;
		idx_s2 <= idx_s1;
		idx_s3 <= idx_s2;
		idx_s4 <= idx_s3;
		for (int i = 0; i < LANES; i++) begin
			mag_s2[i] <= mag_c[i][mvm_pkg::MAG_W-1:0];
			sat_s2[i] <= |mag_c[i][mvm_pkg::DIFF_W-1:mvm_pkg::MAG_W];
			sq_s3[i]  <= sat_s2[i] ? mvm_pkg::DIST_MAX
			                       : mvm_pkg::DIST_W'(mag_s2[i]) * mvm_pkg::DIST_W'(mag_s2[i]);
		end
		dist_s4 <= (|sum_c[mvm_pkg::DIST_W+1:mvm_pkg::DIST_W]) ? mvm_pkg::DIST_MAX
		                                                      : sum_c[mvm_pkg::DIST_W-1:0];
	end

	always_comb begin
		stat.busy    = v_s1 | v_s2 | v_s3 | v_s4;
		stat.valid   = v_s4;
		stat.idx     = idx_s4;
		stat.sq_dist = dist_s4;
	end

endmodule

// File: src/mvm_ctrl.sv
module mvm_ctrl #(
	parameter int MAX_VERTICES = mvm_pkg::MAX_VERTICES_DEF,
	localparam int AW          = $clog2(MAX_VERTICES)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  mvm_pkg::query_t             q,
	input  logic [mvm_pkg::LIM_W-1:0]   near_limit,
	input  logic [mvm_pkg::LIM_W-1:0]   exact_limit,
	input  logic [mvm_pkg::CNT_W-1:0]   vertex_count,
	input  mvm_pkg::dist_stat_t         stat,
	input  logic                        rsp_ready,
	output logic                        idle,
	output logic [AW-1:0]               raddr,
	output mvm_pkg::dist_ctl_t          ctl,
	output mvm_pkg::rsp_t               rsp
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SRC  = 4'b0010,
		ST_SCAN = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t                      state_q;
	logic [mvm_pkg::CNT_W-1:0]   scan_q, count_q, clamp_c;
	logic [mvm_pkg::DIST_W-1:0]  best_q;
	logic [mvm_pkg::IDX_W-1:0]   best_idx_q, match_q, src_idx_q;
	logic [mvm_pkg::SQ_W-1:0]    exact_sq_q, near_sq_q;
	logic                        hit_q;
	mvm_pkg::rsp_t               rsp_q;

	logic issue_c, exact_c, better_c, near_ok_c, out_free_c;

	always_comb begin
		clamp_c    = (32'(vertex_count) > MAX_VERTICES) ? mvm_pkg::CNT_W'(MAX_VERTICES)
		                                                : vertex_count;
		exact_c    = (state_q == ST_SCAN) && stat.valid
		             && (stat.sq_dist <= mvm_pkg::DIST_W'(exact_sq_q));
		better_c   = (state_q == ST_SCAN) && stat.valid && (stat.sq_dist < best_q);
		issue_c    = ((state_q == ST_SRC) || (state_q == ST_SCAN)) && (scan_q < count_q)
		             && !exact_c;
		near_ok_c  = best_q <= mvm_pkg::DIST_W'(near_sq_q);
		out_free_c = !rsp_q.valid || rsp_ready;

		idle         = (state_q == ST_IDLE);
		raddr        = idle ? AW'(q.index) : AW'(scan_q);
		ctl.load_src = (state_q == ST_SRC);
		ctl.issue    = issue_c;
		ctl.flush    = exact_c;
		ctl.idx      = mvm_pkg::IDX_W'(scan_q);
		rsp          = rsp_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			scan_q     <= '0;
			count_q    <= '0;
			best_q     <= mvm_pkg::DIST_MAX;
			best_idx_q <= '0;
			match_q    <= '0;
			src_idx_q  <= '0;
			exact_sq_q <= '0;
			near_sq_q  <= '0;
			hit_q      <= 1'b0;
			rsp_q      <= '0;
		end else begin
			if (rsp_q.valid && rsp_ready && (state_q != ST_DONE)) begin
				rsp_q.valid <= 1'b0;
			end
			if (issue_c) begin
				scan_q <= scan_q + 1'b1;
			end
			if (better_c && !exact_c) begin
				best_q     <= stat.sq_dist;
				best_idx_q <= stat.idx;
			end
			case (state_q)
				ST_IDLE: begin
					if (q.start) begin
						scan_q     <= '0;
						count_q    <= q.in_range ? clamp_c : '0;
						best_q     <= mvm_pkg::DIST_MAX;
						best_idx_q <= '0;
						hit_q      <= 1'b0;
						src_idx_q  <= q.index;
						exact_sq_q <= mvm_pkg::SQ_W'(exact_limit) * mvm_pkg::SQ_W'(exact_limit);
						near_sq_q  <= mvm_pkg::SQ_W'(near_limit) * mvm_pkg::SQ_W'(near_limit);
						state_q    <= ST_SRC;
					end
				end
				ST_SRC: begin
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (exact_c) begin
						hit_q   <= 1'b1;
						match_q <= stat.idx;
						state_q <= ST_DONE;
					end else if (!issue_c && !stat.busy) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					// hold until the output register is free
					if (out_free_c) begin
						rsp_q.valid        <= 1'b1;
						rsp_q.source_index <= src_idx_q;
						if (hit_q) begin
							rsp_q.match_kind  <= mvm_pkg::KIND_EXACT;
							rsp_q.match_index <= match_q;
						end else if (near_ok_c) begin
							rsp_q.match_kind  <= mvm_pkg::KIND_NEAR;
							rsp_q.match_index <= best_idx_q;
						end else begin
							rsp_q.match_kind  <= mvm_pkg::KIND_NONE;
							rsp_q.match_index <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !stat.busy)
		else $error("distance pipeline not empty while idle");

	a_hit_ends_scan: assert property (@(posedge clk) disable iff (!arst_n)
		hit_q |-> ((state_q == ST_DONE) || (state_q == ST_IDLE)))
		else $error("exact hit flag set while scanning");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (scan_q <= count_q))
		else $error("scan ran past vertex count");

	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_q.valid && (rsp_q.match_kind == mvm_pkg::KIND_NONE)) |-> (rsp_q.match_index == '0))
		else $error("no-match word carries a nonzero index");

	a_flush_stops: assert property (@(posedge clk) disable iff (!arst_n)
		exact_c |=> !stat.busy)
		else $error("pipeline not flushed after exact hit");

endmodule

// File: src/mirror_vertex_match.sv
// channel  dir  handshake      word
// cmd      in   valid/ready    opcode, vertex_index, coord_x, coord_y, coord_z
// result   out  valid/ready    source_index, match_index, match_kind
// cfg      in   cfg_we         cfg_index, cfg_data (write only)
//
// A load writes the position store on acceptance when its index is in range.
// A query reads the source position from the store, then streams one vertex per
// cycle through the store read port and the four-stage distance unit.
// An exact hit ends the scan early. cmd is not ready until the query's word
// sits in the result register; a full result register holds the sequencer.
// Reset restores the registers to their defaults; the store is not cleared.
module mirror_vertex_match #(
	parameter int MAX_VERTICES = mvm_pkg::MAX_VERTICES_DEF,
	parameter int COORD_BITS   = mvm_pkg::COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	mvm_cmd_if.sink                      cmd,
	mvm_result_if.source                 result,
	input  logic                         cfg_we,
	input  logic [mvm_pkg::REG_W-1:0]    cfg_index,
	input  logic [mvm_pkg::DATA_W-1:0]   cfg_data
);

	localparam int AW = $clog2(MAX_VERTICES);

	logic [mvm_pkg::AXIS_W-1:0] axis_q;
	logic [mvm_pkg::LIM_W-1:0]  near_q, exact_q;
	logic [mvm_pkg::CNT_W-1:0]  count_q;

	logic                       idle, accept, in_range, store_we;
	logic [AW-1:0]              raddr;
	logic [3*COORD_BITS-1:0]    rd_word;
	mvm_pkg::query_t            query;
	mvm_pkg::dist_ctl_t         dist_ctl;
	mvm_pkg::dist_stat_t        dist_stat;
	mvm_pkg::rsp_t              rsp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_q  <= mvm_pkg::AXIS_X;
			near_q  <= mvm_pkg::NEAR_RESET;
			exact_q <= '0;
			count_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				mvm_pkg::REG_AXIS:  axis_q  <= cfg_data[mvm_pkg::AXIS_W-1:0];
				mvm_pkg::REG_NEAR:  near_q  <= cfg_data[mvm_pkg::LIM_W-1:0];
				mvm_pkg::REG_EXACT: exact_q <= cfg_data[mvm_pkg::LIM_W-1:0];
				mvm_pkg::REG_COUNT: count_q <= cfg_data[mvm_pkg::CNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		accept         = cmd.valid && idle;
		in_range       = 32'(cmd.vertex_index) < MAX_VERTICES;
		store_we       = accept && (cmd.opcode == mvm_pkg::OP_LOAD) && in_range;
		query.start    = accept && (cmd.opcode == mvm_pkg::OP_QUERY);
		query.index    = cmd.vertex_index;
		query.in_range = in_range;
	end

	assign cmd.ready           = idle;
	assign result.valid        = rsp.valid;
	assign result.source_index = rsp.source_index;
	assign result.match_index  = rsp.match_index;
	assign result.match_kind   = rsp.match_kind;

	mvm_store #(
		.MAX_VERTICES (MAX_VERTICES),
		.COORD_BITS   (COORD_BITS)
	) u_store (
		.clk   (clk),
		.we    (store_we),
		.waddr (AW'(cmd.vertex_index)),
		.wdata ({cmd.coord_z, cmd.coord_y, cmd.coord_x}),
		.raddr (raddr),
		.rdata (rd_word)
	);

	mvm_dist #(
		.COORD_BITS (COORD_BITS)
	) u_dist (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (dist_ctl),
		.axis    (axis_q),
		.rd_word (rd_word),
		.stat    (dist_stat)
	);

	mvm_ctrl #(
		.MAX_VERTICES (MAX_VERTICES)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.q            (query),
		.near_limit   (near_q),
		.exact_limit  (exact_q),
		.vertex_count (count_q),
		.stat         (dist_stat),
		.rsp_ready    (result.ready),
		.idle         (idle),
		.raddr        (raddr),
		.ctl          (dist_ctl),
		.rsp          (rsp)
	);

endmodule
